// ===== design/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared field widths, request and status codes, and the command bundle
// that the list controller passes to the slot array.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int OP_W   = 2;
   localparam int POS_W  = 5;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 5;
   localparam int ST_W   = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_EDIT   = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   // One command per transaction that leaves the input stage.
   typedef struct packed {
      logic             shift_in;   // insert: open a gap at pos
      logic             shift_out;  // delete: close the gap at pos
      logic             write;      // insert or edit: store word at pos
      logic [POS_W-1:0] pos;
   } slot_cmd_type;

endpackage

// ===== design/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to CAPACITY words with insert, edit, delete and read
// at a position; every transaction returns status and the entry count.
//
//   channel  ports                                   direction
//   req      req_valid/ready, op, position, entry    in
//   rsp      rsp_valid/ready, status, read_entry,    out
//            length
//
// One transaction per cycle sustained while rsp_ready holds; rsp_valid rises once
// the req has passed the input register, then the result register.
// The slot array shifts all entries at once, so every operation finishes as the
// transaction moves from the input register to the result register.
// Reset clears the valid flags and the count; slot contents are not cleared.
// A stalled rsp holds the result and lets one more transaction wait in the
// input register before req_ready drops.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
   parameter int CAPACITY    = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ple_pkg::OP_W-1:0]   req_op,
   input  logic [ple_pkg::POS_W-1:0]  req_position,
   input  logic [ple_pkg::DATA_W-1:0] req_entry,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ple_pkg::ST_W-1:0]   rsp_status,
   output logic [ple_pkg::DATA_W-1:0] rsp_read_entry,
   output logic [ple_pkg::LEN_W-1:0]  rsp_length
);
   import ple_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [OP_W-1:0]   in_op_ff;
   logic [POS_W-1:0]  in_pos_ff;
   logic [DATA_W-1:0] in_entry_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [DATA_W-1:0] rsp_entry_ff;
   logic [LEN_W-1:0]  rsp_length_ff;
   logic              advance;
   logic              take;
   slot_cmd_type      cmd;
   logic              read_ok;
   logic [ST_W-1:0]   status;
   logic [LEN_W-1:0]  length;
   logic [DATA_W-1:0] rd_word;

   // Advance when the result register is free or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff    <= req_op;
         in_pos_ff   <= req_position;
         in_entry_ff <= req_entry;
      end
   end

   ple_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .op      (in_op_ff),
      .pos     (in_pos_ff),
      .cmd     (cmd),
      .read_ok (read_ok),
      .status  (status),
      .length  (length)
   );

   ple_slot_array #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_slots (
      .clock    (clock),
      .cmd      (cmd),
      .wr_entry (in_entry_ff),
      .rd_word  (rd_word)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status;
         rsp_entry_ff  <= read_ok ? rd_word : '0;
         rsp_length_ff <= length;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_entry = rsp_entry_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

// ===== design/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// Decodes a request against the entry count, checks range and capacity,
// issues the slot command and keeps the occupancy register.
// ----------------------------------------------------------------------------
module ple_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [ple_pkg::OP_W-1:0]  op,
   input  logic [ple_pkg::POS_W-1:0] pos,
   output ple_pkg::slot_cmd_type    cmd,
   output logic                     read_ok,
   output logic [ple_pkg::ST_W-1:0]  status,
   output logic [ple_pkg::LEN_W-1:0] length
);
   import ple_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0] occupancy_ff;
   logic [CNT_W-1:0] occupancy_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] occ_ext;
   logic [CMP_W-1:0] len_ext;
   logic             is_full;
   logic             ok;

   assign pos_ext = CMP_W'(pos);
   assign occ_ext = CMP_W'(occupancy_ff);
   assign is_full = (occupancy_ff == CNT_W'(CAPACITY));

   always_comb begin
      status = ST_DONE;
      if (op == OP_INSERT) begin
         if (pos_ext > occ_ext) begin
            status = ST_RANGE;
         end else if (is_full) begin
            status = ST_FULL;
         end
      end else if (pos_ext >= occ_ext) begin
         status = ST_RANGE;
      end
   end

   assign ok = (status == ST_DONE);

   always_comb begin
      cmd.shift_in  = advance && ok && (op == OP_INSERT);
      cmd.shift_out = advance && ok && (op == OP_DELETE);
      cmd.write     = advance && ok && ((op == OP_INSERT) || (op == OP_EDIT));
      cmd.pos       = pos;
   end

   assign read_ok = ok && (op == OP_READ);

   always_comb begin
      occupancy_in = occupancy_ff;
      if (ok && (op == OP_INSERT)) begin
         occupancy_in = occupancy_ff + CNT_W'(1);
      end else if (ok && (op == OP_DELETE)) begin
         occupancy_in = occupancy_ff - CNT_W'(1);
      end
   end

   // Count after this transaction, cut to the result field.
   assign len_ext = CMP_W'(occupancy_in);
   assign length  = len_ext[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
      end else if (advance) begin
         occupancy_ff <= occupancy_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && !ok) |=> $stable(occupancy_ff))
      else $error("refused request changed occupancy");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_in |=> (occupancy_ff == $past(occupancy_ff) + CNT_W'(1)))
      else $error("insert did not grow the list by one");

endmodule

// ===== design/ple_slot_array.sv =====
// ----------------------------------------------------------------------------
// ple_slot_array
// Register array of list entries. Each slot takes its neighbor, the new
// word or holds, so insert and delete shift the whole tail at once.
// ----------------------------------------------------------------------------
module ple_slot_array #(
   parameter int CAPACITY    = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                      clock,
   input  ple_pkg::slot_cmd_type     cmd,
   input  logic [ple_pkg::DATA_W-1:0] wr_entry,
   output logic [ple_pkg::DATA_W-1:0] rd_word
);
   import ple_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

   logic [ENTRY_WIDTH-1:0] slot_ff [CAPACITY];
   logic [ENTRY_WIDTH-1:0] slot_in [CAPACITY];
   logic                   slot_we [CAPACITY];
   logic [63:0]            wide_entry;
   logic [ENTRY_WIDTH-1:0] word;
   logic [CMP_W-1:0]       pos_ext;
   logic [ENTRY_WIDTH-1:0] sel_word;
   logic [63:0]            rd_wide;

   assign wide_entry = {32'd0, wr_entry};
   assign word       = wide_entry[ENTRY_WIDTH-1:0];
   assign pos_ext    = CMP_W'(cmd.pos);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_lane
      localparam logic [CMP_W-1:0] LANE = CMP_W'(i);
      logic [ENTRY_WIDTH-1:0] from_prev;
      logic [ENTRY_WIDTH-1:0] from_next;
      logic                   has_prev;
      logic                   has_next;

      if (i == 0) begin : g_head
         assign from_prev = '0;
         assign has_prev  = 1'b0;
      end else begin : g_body
         assign from_prev = slot_ff[i-1];
         assign has_prev  = 1'b1;
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign from_next = '0;
         assign has_next  = 1'b0;
      end else begin : g_mid
         assign from_next = slot_ff[i+1];
         assign has_next  = 1'b1;
      end

      always_comb begin
         slot_we[i] = 1'b0;
         slot_in[i] = slot_ff[i];
         if (cmd.shift_in && has_prev && (LANE > pos_ext)) begin
            slot_we[i] = 1'b1;
            slot_in[i] = from_prev;
         end else if (cmd.write && (LANE == pos_ext)) begin
            slot_we[i] = 1'b1;
            slot_in[i] = word;
         end else if (cmd.shift_out && has_next && (LANE >= pos_ext)) begin
            slot_we[i] = 1'b1;
            slot_in[i] = from_next;
         end
      end

      always_ff @(posedge clock) begin
         if (slot_we[i]) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // Select the addressed slot; positions past the array select nothing.
   always_comb begin
      sel_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CMP_W'(i) == pos_ext) begin
            sel_word = sel_word | slot_ff[i];
         end
      end
   end

   assign rd_wide = 64'(sel_word);
   assign rd_word = rd_wide[DATA_W-1:0];

endmodule

// ===== verif/tb_positional_list_engine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine. A clocked driver feeds
// requests from a queue with random gaps, and a clocked monitor applies
// random back-pressure. Each accepted request runs through an in-bench list
// model whose result is compared field by field with the response stream.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;
   import ple_pkg::*;

   localparam int LIST_CAP    = 16;
   localparam int TOTAL_ITEMS = 1650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] entry;
      bit                hold_drain;  // wait for an empty pipeline first
      bit                calm;        // no idling around this transaction
   } list_req_type;

   typedef struct {
      logic [ST_W-1:0]   status;
      logic [DATA_W-1:0] read_entry;
      logic [LEN_W-1:0]  length;
      logic [OP_W-1:0]   op;
      bit                calm;
   } list_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [DATA_W-1:0]   req_entry = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ST_W-1:0]     rsp_status;
   logic [DATA_W-1:0]   rsp_read_entry;
   logic [LEN_W-1:0]    rsp_length;

   list_req_type        queued_reqs[$];
   list_rsp_type        due_results[$];
   list_req_type        cur_req;

   // list model state
   logic [DATA_W-1:0]   model_slots[LIST_CAP];
   int                  model_count = 0;

   int                  gen_fill = 0;
   bit                  gen_calm = 0;

   int                  accepted = 0;
   int                  received = 0;
   int                  errors = 0;
   int                  cycles = 0;
   int                  gap_left = 0;
   int                  stall_left = 0;
   int                  op_seen[4] = '{0, 0, 0, 0};
   int                  n_range = 0;
   int                  n_full = 0;
   int                  peak_len = 0;
   int                  drain_waits = 0;

   positional_list_engine_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_entry      (req_entry),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_entry (rsp_read_entry),
      .rsp_length     (rsp_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one request to the list model and return the response it owes.
   function automatic list_rsp_type apply_list_op(list_req_type r);
      list_rsp_type res;
      int           p;
      int           i;
      p              = r.pos;
      res.status     = ST_DONE;
      res.read_entry = '0;
      res.op         = r.op;
      res.calm       = r.calm;
      if (r.op == OP_INSERT) begin
         if (p > model_count) begin
            res.status = ST_RANGE;
         end else if (model_count >= LIST_CAP) begin
            res.status = ST_FULL;
         end else begin
            for (i = model_count; i > p; i--) model_slots[i] = model_slots[i-1];
            model_slots[p] = r.entry;
            model_count++;
         end
      end else if (p >= model_count) begin
         res.status = ST_RANGE;
      end else if (r.op == OP_EDIT) begin
         model_slots[p] = r.entry;
      end else if (r.op == OP_DELETE) begin
         for (i = p; i + 1 < model_count; i++) model_slots[i] = model_slots[i+1];
         model_count--;
      end else begin
         res.read_entry = model_slots[p];
      end
      res.length = LEN_W'(model_count);
      return res;
   endfunction

   // Queue a request and track the fill level the stimulus will reach.
   task automatic queue_req(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] entry,
                            bit hold);
      list_req_type r;
      r.op         = op;
      r.pos        = POS_W'(pos);
      r.entry      = entry;
      r.hold_drain = hold;
      r.calm       = gen_calm;
      queued_reqs.insert(queued_reqs.size(), r);
      if (op == OP_INSERT && pos <= gen_fill && gen_fill < LIST_CAP) gen_fill++;
      else if (op == OP_DELETE && pos < gen_fill) gen_fill--;
   endtask

   // Driver: present queued transactions, hold them until accepted.
   always @(posedge clock) begin
      bit took;
      took = req_valid && req_ready;
      if (!reset) begin
         if (took) begin
            due_results.insert(due_results.size(), apply_list_op(cur_req));
            accepted <= accepted + 1;
         end
         if (!req_valid || took) begin
            if (queued_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (queued_reqs[0].hold_drain && (took || accepted != received)) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else begin
               cur_req = queued_reqs.pop_front();
               if (cur_req.hold_drain) drain_waits++;
               req_valid    <= 1'b1;
               req_op       <= cur_req.op;
               req_position <= cur_req.pos;
               req_entry    <= cur_req.entry;
               gap_left = cur_req.calm ? 0 : $urandom_range(0, 15);
            end
         end
      end
   end

   // Monitor: check each response against the oldest one owed.
   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         received <= received + 1;
         want.calm = 0;
         if (received >= accepted) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with no transaction outstanding", $realtime);
         end else begin
            want = due_results.pop_front();
            op_seen[want.op]++;
            if (want.status == ST_RANGE) n_range++;
            if (want.status == ST_FULL) n_full++;
            if (want.length > peak_len) peak_len = want.length;
            if (rsp_status !== want.status || rsp_read_entry !== want.read_entry ||
                rsp_length !== want.length) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: response %0d op %0d: expected status %0d entry %h len %0d,",
                           $realtime, received, want.op, want.status, want.read_entry,
                           want.length);
                  $display("   got status %0d entry %h len %0d",
                           rsp_status, rsp_read_entry, rsp_length);
               end
            end
         end
         stall_left = want.calm ? 0 : $urandom_range(0, 15);
         rsp_ready <= (stall_left == 0);
      end else if (!rsp_ready) begin
         if (stall_left > 0) stall_left--;
         if (stall_left == 0) rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout: %0d accepted, %0d responses after %0d cycles",
                  accepted, received, cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] entry;
      int                pos;
      int                mode;
      int                run_len;
      int                k;

      // directed: refusals on empty, head/tail inserts, edit, deletes
      queue_req(OP_READ,   0,  32'h1234_5678, 0);
      queue_req(OP_DELETE, 0,  32'h0,         0);
      queue_req(OP_EDIT,   0,  32'hFFFF_FFFF, 0);
      queue_req(OP_INSERT, 1,  32'hDEAD_BEEF, 0);
      queue_req(OP_INSERT, 31, 32'hFFFF_FFFF, 0);
      queue_req(OP_INSERT, 0,  32'hFFFF_FFFF, 1);
      queue_req(OP_INSERT, 0,  32'h0000_0000, 0);
      queue_req(OP_INSERT, 2,  32'hA5A5_A5A5, 0);
      queue_req(OP_READ,   0,  32'hFFFF_FFFF, 0);
      queue_req(OP_READ,   1,  32'h0,         0);
      queue_req(OP_READ,   2,  32'h0,         0);
      queue_req(OP_READ,   3,  32'h0,         0);
      queue_req(OP_READ,   31, 32'h0,         0);
      queue_req(OP_EDIT,   1,  32'h5A5A_5A5A, 0);
      queue_req(OP_READ,   1,  32'h0,         0);
      queue_req(OP_EDIT,   3,  32'h1,         0);
      queue_req(OP_DELETE, 1,  32'hFFFF_FFFF, 0);
      queue_req(OP_READ,   1,  32'h0,         0);
      queue_req(OP_DELETE, 1,  32'h0,         0);
      queue_req(OP_DELETE, 0,  32'h0,         0);
      queue_req(OP_READ,   0,  32'h0,         0);
      queue_req(OP_DELETE, 16, 32'h0,         0);

      // random runs: fill, drain, mixed in-range, and noise
      while (queued_reqs.size() < TOTAL_ITEMS) begin
         mode     = $urandom_range(0, 3);
         run_len  = $urandom_range(20, 60);
         gen_calm = ($urandom_range(0, 4) == 0);
         for (k = 0; k < run_len; k++) begin
            case (mode)
               0: op = ($urandom_range(0, 3) != 0) ? OP_INSERT : OP_W'($urandom_range(1, 3));
               1: op = ($urandom_range(0, 9) < 7) ? OP_DELETE : OP_W'($urandom_range(0, 3));
               default: op = OP_W'($urandom_range(0, 3));
            endcase
            if (mode == 3 || $urandom_range(0, 19) == 0) begin
               pos = $urandom_range(0, 31);
            end else if (op == OP_INSERT) begin
               pos = ($urandom_range(0, 19) < 3) ? gen_fill : $urandom_range(0, gen_fill);
            end else if (gen_fill == 0) begin
               pos = 0;
            end else begin
               pos = ($urandom_range(0, 19) < 3) ? gen_fill - 1
                                                 : $urandom_range(0, gen_fill - 1);
            end
            case ($urandom_range(0, 9))
               0:       entry = '0;
               1:       entry = '1;
               default: entry = $urandom;
            endcase
            queue_req(op, pos, entry, $urandom_range(0, 199) == 0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (queued_reqs.size() != 0 || req_valid || accepted != received) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d transactions: %0d insert, %0d edit, %0d delete, %0d read",
               accepted, op_seen[OP_INSERT], op_seen[OP_EDIT], op_seen[OP_DELETE],
               op_seen[OP_READ]);
      $display("refused: %0d out of range, %0d list full; peak length %0d; %0d drain pauses",
               n_range, n_full, peak_len, drain_waits);
      if (errors == 0 && due_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, due_results.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ple_pkg.sv
design/ple_ctrl.sv
design/ple_slot_array.sv
design/positional_list_engine_top.sv
verif/tb_positional_list_engine_top.sv
